[design/cmt_pkg.sv]
// Shared types and constants for the complement match table.
`timescale 1ns / 1ps

package cmt_pkg;

   localparam int KEY_BITS = 32;

   // Outcome of one table lookup
   typedef struct packed {
      logic comp_hit;   // complement found among stored keys
      logic self_hit;   // the value itself is already stored
      logic full;       // no free entry left for a new key
   } lookup_type;

endpackage

[design/cmt_if.sv]
// Handshake channels for request and response beats of the complement match table.
`timescale 1ns / 1ps

interface cmt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_value;
   logic               start_of_set;

   modport source (output valid, output sample_value, output start_of_set, input ready);
   modport sink   (input valid, input sample_value, input start_of_set, output ready);
endinterface

interface cmt_rsp_if #(
   parameter int POSITION_BITS = 16
);
   logic                     valid;
   logic                     ready;
   logic [POSITION_BITS-1:0] current_position;
   logic [POSITION_BITS-1:0] partner_position;
   logic                     store_overflow;

   modport source (output valid, output current_position, output partner_position,
                   output store_overflow, input ready);
   modport sink   (input valid, input current_position, input partner_position,
                   input store_overflow, output ready);
endinterface

[design/cmt_table.sv]
// Content-addressed key/position store with parallel complement and key lookup.
`timescale 1ns / 1ps

module cmt_table
   import cmt_pkg::*;
#(
   parameter int TABLE_DEPTH   = 64,
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     commit,
   input  logic                     clear,
   input  logic [KEY_BITS-1:0]      comp_key,
   input  logic                     comp_ok,
   input  logic [KEY_BITS-1:0]      sample,
   input  logic [POSITION_BITS-1:0] pos,
   output lookup_type               lookup,
   output logic [POSITION_BITS-1:0] partner_pos
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [KEY_BITS-1:0]      key_ff [TABLE_DEPTH];
   logic [POSITION_BITS-1:0] pos_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   valid_ff, valid_in, valid_eff;
   logic [CNT_W-1:0]         count_ff, count_in, count_eff;
   logic [TABLE_DEPTH-1:0]   comp_match, self_match;
   logic [IDX_W-1:0]         wr_idx;
   logic                     do_insert;

   // A start beat sees an empty table
   assign valid_eff = clear ? '0 : valid_ff;
   assign count_eff = clear ? '0 : count_ff;
   assign wr_idx    = count_eff[IDX_W-1:0];

   always_comb begin
      partner_pos = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         comp_match[i] = valid_eff[i] && comp_ok && (key_ff[i] == comp_key);
         self_match[i] = valid_eff[i] && (key_ff[i] == sample);
         partner_pos   = partner_pos | (pos_ff[i] & {POSITION_BITS{comp_match[i]}});
      end
      lookup.comp_hit = |comp_match;
      lookup.self_hit = |self_match;
      lookup.full     = (count_eff == CNT_W'(TABLE_DEPTH));
   end

   assign do_insert = commit && !lookup.comp_hit && !lookup.self_hit && !lookup.full;

   always_comb begin
      valid_in = valid_eff;
      count_in = count_eff;
      if (do_insert) begin
         valid_in[wr_idx] = 1'b1;
         count_in         = count_eff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (commit) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Refresh the position of a stored key, or fill the next free entry
   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (commit && !lookup.comp_hit && self_match[i]) begin
            pos_ff[i] <= pos;
         end else if (do_insert && (wr_idx == IDX_W'(i))) begin
            key_ff[i] <= sample;
            pos_ff[i] <= pos;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_keys_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(self_match))
      else $error("same key stored twice");

   a_insert_marks_valid: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> valid_ff[$past(wr_idx)] && (count_ff == $past(count_eff) + CNT_W'(1)))
      else $error("inserted entry not marked valid");
`endif

endmodule

[design/complement_match_table.sv]
// Top level of the complement match table: input stage, position counter and result stage.
// A request beat is held in the input stage, then registered in the result stage; only a complement
//   hit or an overflow (full table, key not stored) gives a response beat. Throughput: one request
//   beat per cycle while rsp.ready keeps the result slot free; cmt_table compares all entries in parallel.
// Reset (synchronous): clears target_ff, entry valid bits, fill count, position
//   counter and both stage valids; stored keys need no clearing pass.
`timescale 1ns / 1ps

module complement_match_table
   import cmt_pkg::*;
#(
   parameter int TABLE_DEPTH   = 64,
   parameter int POSITION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   cmt_req_if.sink             req,
   cmt_rsp_if.source           rsp,
   input  logic                csr_wr_en,
   input  logic [KEY_BITS-1:0] csr_wr_data
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   logic [KEY_BITS-1:0]      target_ff;
   logic                     in_valid_ff;
   logic [KEY_BITS-1:0]      in_sample_ff;
   logic                     in_start_ff;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_eff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POSITION_BITS-1:0] rsp_cur_ff, rsp_cur_in;
   logic [POSITION_BITS-1:0] rsp_partner_ff, rsp_partner_in;
   logic                     rsp_over_ff, rsp_over_in;
   logic                     fire, emit;
   logic [KEY_BITS:0]        comp;
   logic                     comp_ok;
   lookup_type               lookup;
   logic [POSITION_BITS-1:0] partner_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // Process the held beat once the result slot is free after this edge
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_sample_ff <= req.sample_value;
         in_start_ff  <= req.start_of_set;
      end
   end

   // Exact complement; out of 32-bit range when the two top bits differ
   assign comp    = {target_ff[KEY_BITS-1], target_ff} - {in_sample_ff[KEY_BITS-1], in_sample_ff};
   assign comp_ok = (comp[KEY_BITS] == comp[KEY_BITS-1]);

   assign pos_eff = in_start_ff ? '0 : pos_ff;
   assign pos_in  = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + POSITION_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (fire) begin
         pos_ff <= pos_in;
      end
   end

   cmt_table #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .POSITION_BITS (POSITION_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .commit      (fire),
      .clear       (in_start_ff),
      .comp_key    (comp[KEY_BITS-1:0]),
      .comp_ok     (comp_ok),
      .sample      (in_sample_ff),
      .pos         (pos_eff),
      .lookup      (lookup),
      .partner_pos (partner_pos)
   );

   assign emit = lookup.comp_hit || (!lookup.self_hit && lookup.full);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_cur_in     = rsp_cur_ff;
      rsp_partner_in = rsp_partner_ff;
      rsp_over_in    = rsp_over_ff;
      if (fire && emit) begin
         rsp_valid_in   = 1'b1;
         rsp_over_in    = !lookup.comp_hit;
         rsp_cur_in     = lookup.comp_hit ? pos_eff : '0;
         rsp_partner_in = lookup.comp_hit ? partner_pos : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cur_ff     <= rsp_cur_in;
      rsp_partner_ff <= rsp_partner_in;
      rsp_over_ff    <= rsp_over_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.current_position = rsp_cur_ff;
   assign rsp.partner_position = rsp_partner_ff;
   assign rsp.store_overflow   = rsp_over_ff;

`ifndef SYNTHESIS
   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_over_ff |-> (rsp_cur_ff == '0) && (rsp_partner_ff == '0))
      else $error("overflow beat with non-zero positions");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_sample_ff))
      else $error("held request beat lost during stall");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      fire && (pos_eff == POS_MAX) |=> pos_ff == POS_MAX)
      else $error("position counter wrapped");
`endif

endmodule
